[src/ais_pkg.sv]
package ais_pkg;

    localparam int VALUE_W = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;   // an input request is taken this cycle
        logic shift;    // the head result is taken this cycle
        logic finish;   // the final result of the set is taken this cycle
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_one; // exactly one element is left in the store
    } t_status;

endpackage

[src/ascending_integer_sorter.sv]
// Loading takes one request per cycle; each element kept is placed in sorted order as it arrives.
// The first result is offered in the cycle after the request flagged last is taken.
// Results then leave one per cycle while the consumer is ready, shifted out of the store head.
// Requests that arrive while the store is full are dropped and set the overflow flag.
// No new set is taken while draining; the input reopens right after the final result.
// Reset (i_rst_n low, synchronous) empties the store and clears the overflow flag.
module ascending_integer_sorter #(
    parameter int CAPACITY = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input channel: one element per request.
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [ais_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_last,
    // Output channel: one sorted element per request.
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [ais_pkg::VALUE_W-1:0] o_value_res,
    output logic                               o_last_res,
    output logic                               o_overflow
);

    // The controller decides which requests are taken; the datapath holds the
    // sorted store of insertion cells, the fill count and the overflow flag.
    ais_pkg::t_cmd    w_cmd;
    ais_pkg::t_status w_status;

    ais_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_last   (i_last),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .o_cmd    (w_cmd)
    );

    // While collecting, every cell decides in parallel whether it keeps its
    // element, takes its lower neighbor's, or takes the new value. While
    // draining, the store shifts toward cell zero, which drives the result.
    ais_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_value     (i_value),
        .o_status    (w_status),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res),
        .o_overflow  (o_overflow)
    );

endmodule

[src/ais_ctrl.sv]
module ais_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_last,
    input  logic               i_ready,
    input  ais_pkg::t_status   i_status,
    output logic               o_ready,
    output logic               o_valid,
    output ais_pkg::t_cmd      o_cmd
);

    typedef enum logic [0:0] {
        S_COLLECT,
        S_DRAIN
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   w_in_take;
    logic   w_out_take;

    assign w_in_take  = i_valid && r_in_ready;
    assign w_out_take = r_out_valid && i_ready;

    assign o_ready      = r_in_ready;
    assign o_valid      = r_out_valid;
    assign o_cmd.insert = w_in_take;
    assign o_cmd.shift  = w_out_take;
    assign o_cmd.finish = w_out_take && i_status.last_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_COLLECT: begin
                    if (w_in_take && i_last) begin
                        r_state     <= S_DRAIN;
                        r_in_ready  <= 1'b0;
                        r_out_valid <= 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (w_out_take && i_status.last_one) begin
                        r_state     <= S_COLLECT;
                        r_in_ready  <= 1'b1;
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state     <= S_COLLECT;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

endmodule

[src/ais_datapath.sv]
module ais_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ais_pkg::t_cmd                      i_cmd,
    input  logic signed [ais_pkg::VALUE_W-1:0] i_value,
    output ais_pkg::t_status                   o_status,
    output logic signed [ais_pkg::VALUE_W-1:0] o_value_res,
    output logic                               o_last_res,
    output logic                               o_overflow
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [ais_pkg::VALUE_W-1:0] r_store [CAPACITY];
    logic signed [ais_pkg::VALUE_W-1:0] n_store [CAPACITY];
    logic [CW-1:0]                      r_count;
    logic                               r_dropped;
    logic [CAPACITY-1:0]                w_gt;
    logic                               w_full;

    assign w_full            = (r_count == CW'(CAPACITY));
    assign o_status.last_one = (r_count == CW'(1));
    assign o_value_res       = r_store[0];
    assign o_last_res        = o_status.last_one;
    assign o_overflow        = r_dropped;

    // Each cell compares its element with the incoming value; the store stays
    // sorted, so the cells holding greater elements form a contiguous tail.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_gt[i] = (CW'(i) < r_count) && (r_store[i] > i_value);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_store[i] = r_store[i];
            if (i_cmd.shift) begin
                if (i < CAPACITY - 1) begin
                    n_store[i] = r_store[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end else if (i_cmd.insert && !w_full && (CW'(i) <= r_count)) begin
                if ((i > 0) && w_gt[(i > 0) ? i - 1 : 0]) begin
                    n_store[i] = r_store[(i > 0) ? i - 1 : 0];
                end else if (w_gt[i] || (CW'(i) == r_count)) begin
                    n_store[i] = i_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.shift) begin
            r_count <= r_count - CW'(1);
            if (i_cmd.finish) begin
                r_dropped <= 1'b0;
            end
        end else if (i_cmd.insert) begin
            if (w_full) begin
                r_dropped <= 1'b1;
            end else begin
                r_count <= r_count + CW'(1);
            end
        end
    end

endmodule

[src/ais_checker.sv]
module ais_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_last,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_value_res,
    input logic        o_last_res,
    input logic        o_overflow
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value_res) && $stable(o_last_res))
        else $error("stalled result changed");

    // The block never collects and drains at once.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while a result is offered");

    // Taking the closing request starts the drain in the next cycle.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_last |=> o_valid && !o_ready)
        else $error("drain did not start after the closing request");

    // Taking the final result reopens the input with a clear overflow flag.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last_res |=> o_ready && !o_valid && !o_overflow)
        else $error("input not reopened after the final result");

endmodule

bind ascending_integer_sorter ais_checker u_ais_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_last      (i_last),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_value_res (o_value_res),
    .o_last_res  (o_last_res),
    .o_overflow  (o_overflow)
);
